@@ hw/rtl/twrtc_pkg.sv @@
// twrtc_pkg: shared types, constants and BCD helpers for the three-wire RTC bus master.
// No dependencies; used by all modules under hw/rtl.
`default_nettype none

package twrtc_pkg;

  // Input stream tdata layout (tuser carries mode)
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 16;

  // APB-style configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [0:0]  REG_HALF_PERIOD = 1'b0;  // register select, paddr[2]
  localparam logic [7:0]  HALF_PERIOD_RESET = 8'd4;

  // Bit timing constants
  localparam logic [2:0] LAST_BIT = 3'd7;
  localparam logic [6:0] MAX_DEC  = 7'd99;

  // Classified item handed from front to back
  typedef struct packed {
    logic       start;
    logic       is_read;
    logic [7:0] cmd_byte;   // address, or address+1 for reads
    logic [7:0] bcd_byte;   // saturated write value in packed BCD
    logic       line_in;
  } twrtc_item_t;

  // Saturate to 99, then split into tens and ones (reciprocal multiply by 205/2048)
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [6:0]  d;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  ones;
    d        = (v > MAX_DEC) ? MAX_DEC : v;
    prod     = {8'd0, d} * 15'd205;
    tens     = prod[14:11];
    tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
    ones     = d - tens_x10;
    return {tens, ones[3:0]};
  endfunction

  // hi*10 + lo, invalid digits included (max 165)
  function automatic logic [7:0] from_bcd(input logic [7:0] b);
    return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/three_wire_rtc_bus_master.sv @@
// Three-wire RTC bus master, top level.
// Each input transfer is one tick of the pin sequencer; each tick yields exactly one
// result transfer with the pin levels, busy/done flags and the last decoded read value.
// Channels: in_* stream (tdata: start_req, address, write_value, line_in; tuser: mode),
// out_* stream (tdata: pin levels, flags, read_value), cfg_* APB-style register port.
// Register 0 (byte address 0): half_period_ticks, reset 4; 0 behaves as 1.
// Each accepted tick is written into the queue; once it is at the head (at once when the
// queue was empty) it is popped into the output register, from which its result is taken.
// Throughput: one tick per cycle while out_tready is high; the back-end sequencer steps once
// per tick and the two-entry queue lets the front keep accepting while the output register waits.
// Reset (rst_n low, synchronous): sequencer idle, queue empty, no result pending,
// half period back to 4. When out_tready is low the result is held, the queue fills
// and in_tready drops once both entries are taken; nothing is lost or repeated.
// A write access lasts 32 half periods, a read 31; done pulses on the closing tick.
// Depends on twrtc_pkg, twrtc_front, twrtc_queue, twrtc_back.
`default_nettype none

module three_wire_rtc_bus_master (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // start_req[0], address[8:1], write_value[15:9], line_in[16], zero[23:17]
  input  wire logic [twrtc_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode[0]
  input  wire logic                             in_tuser,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // chip_enable[0], serial_clock[1], line_out[2], line_drive[3], busy_res[4],
  // done_res[5], read_value[13:6], zero[15:14]
  output logic [twrtc_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [twrtc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [twrtc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [twrtc_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                  cfg_pready
);

  logic [7:0]             half_period_r;
  logic                   cfg_wr;
  logic                   q_full, q_empty, q_push, q_pop;
  twrtc_pkg::twrtc_item_t push_item, head_item;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == twrtc_pkg::REG_HALF_PERIOD) ?
                      {24'd0, half_period_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= twrtc_pkg::HALF_PERIOD_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == twrtc_pkg::REG_HALF_PERIOD)) begin
      half_period_r <= cfg_pwdata[7:0];
    end
  end

  twrtc_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  twrtc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  twrtc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .half_period (half_period_r),
    .q_item      (head_item),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

`default_nettype wire

@@ hw/rtl/twrtc_front.sv @@
// twrtc_front: accepts input transfers and classifies them into queue items.
// Depends on twrtc_pkg (item type, BCD conversion).
`default_nettype none

module twrtc_front (
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [twrtc_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic                               in_tuser,
  input  wire logic                               q_full,
  output logic                                    q_push,
  output twrtc_pkg::twrtc_item_t                  q_item
);

  logic [7:0] address;
  logic [6:0] write_value;

  assign address     = in_tdata[8:1];
  assign write_value = in_tdata[15:9];

  // Handshake against queue space
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Precompute the command byte and the BCD data byte
  always_comb begin
    q_item.start    = in_tdata[0];
    q_item.is_read  = in_tuser;
    q_item.cmd_byte = in_tuser ? (address + 8'd1) : address;
    q_item.bcd_byte = twrtc_pkg::to_bcd(write_value);
    q_item.line_in  = in_tdata[16];
  end

endmodule

`default_nettype wire

@@ hw/rtl/twrtc_queue.sv @@
// twrtc_queue: two-entry queue between front and back.
// Depends on twrtc_pkg (item type).
`default_nettype none

module twrtc_queue (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire twrtc_pkg::twrtc_item_t push_item,
  input  wire logic                   pop,
  output twrtc_pkg::twrtc_item_t      head_item,
  output logic                        full,
  output logic                        empty
);

  twrtc_pkg::twrtc_item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r,  count_nxt;

  assign full      = count_r == 2'd2;
  assign empty     = count_r == 2'd0;
  assign head_item = mem_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/twrtc_back.sv @@
// twrtc_back: pin sequencer; steps once per queued tick and registers the result transfer.
// Depends on twrtc_pkg (item type, constants, BCD decode).
`default_nettype none

module twrtc_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [7:0]                         half_period,
  input  wire twrtc_pkg::twrtc_item_t             q_item,
  input  wire logic                               q_empty,
  output logic                                    q_pop,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [twrtc_pkg::OUT_DATA_W-1:0]        out_tdata
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_TX_LOW  = 3'd1,
    PH_TX_HIGH = 3'd2,
    PH_RX_LOW  = 3'd3,
    PH_RX_HIGH = 3'd4
  } phase_t;

  phase_t     phase_r,     phase_nxt;
  logic [2:0] bit_r,       bit_nxt;
  logic       byte_r,      byte_nxt;
  logic [7:0] shift_r,     shift_nxt;
  logic [7:0] pend_r,      pend_nxt;
  logic       is_read_r,   is_read_nxt;
  logic [7:0] tick_r,      tick_nxt;
  logic [7:0] last_rd_r,   last_rd_nxt;
  logic       done;
  logic [7:0] hp;
  logic [7:0] sampled;

  logic                                out_valid_r;
  logic [twrtc_pkg::OUT_DATA_W-1:0]    out_data_r, out_data_nxt;
  logic busy, drive, sclk, lout;

  assign hp         = (half_period == 8'd0) ? 8'd1 : half_period;
  assign q_pop      = !q_empty && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign sampled    = shift_r | ({7'd0, q_item.line_in} << bit_r);

  // Next state for one tick
  always_comb begin
    phase_nxt   = phase_r;
    bit_nxt     = bit_r;
    byte_nxt    = byte_r;
    shift_nxt   = shift_r;
    pend_nxt    = pend_r;
    is_read_nxt = is_read_r;
    tick_nxt    = tick_r;
    last_rd_nxt = last_rd_r;
    done        = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (q_item.start) begin
        is_read_nxt = q_item.is_read;
        shift_nxt   = q_item.cmd_byte;
        pend_nxt    = q_item.bcd_byte;
        bit_nxt     = 3'd0;
        byte_nxt    = 1'b0;
        phase_nxt   = PH_TX_LOW;
        tick_nxt    = 8'd1;
      end
    end else if (tick_r < hp) begin
      tick_nxt = tick_r + 8'd1;
    end else begin
      tick_nxt = 8'd1;
      case (phase_r)
        PH_TX_LOW: begin
          phase_nxt = PH_TX_HIGH;
        end
        PH_TX_HIGH: begin
          if (bit_r != twrtc_pkg::LAST_BIT) begin
            bit_nxt   = bit_r + 3'd1;
            phase_nxt = PH_TX_LOW;
          end else if (!byte_r) begin
            bit_nxt = 3'd0;
            if (is_read_r) begin
              shift_nxt = 8'd0;
              phase_nxt = PH_RX_LOW;
            end else begin
              byte_nxt  = 1'b1;
              shift_nxt = pend_r;
              phase_nxt = PH_TX_LOW;
            end
          end else begin
            phase_nxt = PH_IDLE;
            tick_nxt  = 8'd0;
            done      = 1'b1;
          end
        end
        PH_RX_LOW: begin
          shift_nxt = sampled;
          if (bit_r == twrtc_pkg::LAST_BIT) begin
            last_rd_nxt = twrtc_pkg::from_bcd(sampled);
            phase_nxt   = PH_IDLE;
            tick_nxt    = 8'd0;
            done        = 1'b1;
          end else begin
            phase_nxt = PH_RX_HIGH;
          end
        end
        PH_RX_HIGH: begin
          bit_nxt   = bit_r + 3'd1;
          phase_nxt = PH_RX_LOW;
        end
        default: begin
          phase_nxt = PH_IDLE;
          tick_nxt  = 8'd0;
        end
      endcase
    end
  end

  // Pin levels from the updated state
  always_comb begin
    busy  = phase_nxt != PH_IDLE;
    drive = (phase_nxt == PH_TX_LOW) || (phase_nxt == PH_TX_HIGH);
    sclk  = (phase_nxt == PH_TX_HIGH) || (phase_nxt == PH_RX_HIGH);
    lout  = drive && shift_nxt[bit_nxt];
    out_data_nxt = {2'b00, last_rd_nxt, done, busy, drive, lout, sclk, busy};
  end

  // Sequencer state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_r       <= 3'd0;
      byte_r      <= 1'b0;
      shift_r     <= 8'd0;
      pend_r      <= 8'd0;
      is_read_r   <= 1'b0;
      tick_r      <= 8'd0;
      last_rd_r   <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r     <= phase_nxt;
        bit_r       <= bit_nxt;
        byte_r      <= byte_nxt;
        shift_r     <= shift_nxt;
        pend_r      <= pend_nxt;
        is_read_r   <= is_read_nxt;
        tick_r      <= tick_nxt;
        last_rd_r   <= last_rd_nxt;
        out_data_r  <= out_data_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ test/tb_three_wire_rtc_bus_master.sv @@
// Self-checking testbench for the three-wire RTC bus master: one stream transfer per tick
// in, one pin-level result per tick out, predicted by a local sequencer model.
// Depends on twrtc_pkg and three_wire_rtc_bus_master.
`timescale 1ns / 1ps

module tb_three_wire_rtc_bus_master;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int RANDOM_TICKS = 900;
  localparam int NO_CHANGE    = -1;   // half period column: leave register as is
  localparam int PREDICTED    = -1;   // word columns: use the sequencer model
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;
  localparam logic [twrtc_pkg::CFG_ADDR_W-1:0] HALF_PERIOD_ADDR =
    {twrtc_pkg::REG_HALF_PERIOD, 2'b00};

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_TX_LOW, SEQ_TX_HIGH, SEQ_RX_LOW, SEQ_RX_HIGH
  } seq_phase_t;

  // result word, laid out as out_tdata
  typedef struct packed {
    logic [1:0] pad;
    logic [7:0] read_value;
    logic       done;
    logic       busy;
    logic       line_drive;
    logic       line_out;
    logic       serial_clock;
    logic       chip_enable;
  } pin_result_t;

  typedef struct packed {
    int         half_period;
    logic       start;
    logic       mode;
    logic [7:0] address;
    logic [6:0] write_value;
    logic [7:0] rx_byte;
    int         first_word;
    int         done_word;
  } access_row_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic [twrtc_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                             in_tuser = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [twrtc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic                             cfg_psel = 1'b0;
  logic                             cfg_penable = 1'b0;
  logic                             cfg_pwrite = 1'b0;
  logic [twrtc_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [twrtc_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [twrtc_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                             cfg_pready;

  three_wire_rtc_bus_master DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #2 clk = ~clk;

  // sequencer model state
  logic [7:0] seq_half_period = twrtc_pkg::HALF_PERIOD_RESET;
  seq_phase_t seq_phase = SEQ_IDLE;
  logic [2:0] seq_bit = '0;
  logic       seq_second_byte = 1'b0;
  logic [7:0] seq_shift = '0;
  logic [7:0] seq_data_bcd = '0;
  logic       seq_read = 1'b0;
  logic [7:0] seq_ticks = '0;
  logic [7:0] seq_read_value = '0;

  pin_result_t pin_levels_due[$];
  pin_result_t seen_levels;
  pin_result_t want_levels;
  int          failures = 0;
  int          ticks_sent = 0;
  int          cycles = 0;
  int          stall_left = 0;
  bit          steady = 1'b0;
  int          random_start;

  // directed accesses; typed words are read straight off the pin sequence
  access_row_t directed_rows [18] = '{
    '{NO_CHANGE, 1'b0, MODE_WRITE, 8'h00, 7'd0,   8'h00, 'h0000, PREDICTED},
    '{1,         1'b1, MODE_WRITE, 8'hFF, 7'd99,  8'h00, 'h001D, 'h0020},
    '{NO_CHANGE, 1'b1, MODE_WRITE, 8'h80, 7'd127, 8'h00, 'h0019, 'h0020},
    '{NO_CHANGE, 1'b1, MODE_WRITE, 8'h01, 7'd0,   8'h00, 'h001D, 'h0020},
    '{NO_CHANGE, 1'b1, MODE_READ,  8'hFF, 7'd0,   8'h99, 'h0019, 'h18E0},
    '{NO_CHANGE, 1'b1, MODE_READ,  8'h00, 7'd0,   8'hFF, 'h18DD, 'h2960},
    '{NO_CHANGE, 1'b1, MODE_READ,  8'h7E, 7'd0,   8'h00, 'h295D, 'h0020},
    '{NO_CHANGE, 1'b1, MODE_READ,  8'h10, 7'd0,   8'h5A, 'h001D, 'h0F20},
    '{NO_CHANGE, 1'b0, MODE_WRITE, 8'h00, 7'd0,   8'h00, 'h0F00, PREDICTED},
    '{NO_CHANGE, 1'b1, MODE_READ,  8'h20, 7'd0,   8'hA5, 'h0F1D, 'h1A60},
    '{0,         1'b1, MODE_WRITE, 8'h3C, 7'd45,  8'h00, 'h1A59, 'h1A60},
    '{NO_CHANGE, 1'b1, MODE_READ,  8'h41, 7'd0,   8'h42, 'h1A59, 'h0AA0},
    '{255,       1'b0, MODE_WRITE, 8'h00, 7'd0,   8'h00, 'h0A80, PREDICTED},
    '{2,         1'b1, MODE_WRITE, 8'h55, 7'd12,  8'h00, PREDICTED, PREDICTED},
    '{NO_CHANGE, 1'b1, MODE_READ,  8'hFE, 7'd0,   8'h37, PREDICTED, PREDICTED},
    '{4,         1'b1, MODE_READ,  8'h00, 7'd0,   8'h00, PREDICTED, PREDICTED},
    '{NO_CHANGE, 1'b1, MODE_WRITE, 8'hC3, 7'd100, 8'h00, PREDICTED, PREDICTED},
    '{NO_CHANGE, 1'b0, MODE_WRITE, 8'h00, 7'd0,   8'h00, PREDICTED, PREDICTED}
  };

  // one tick of the pin sequencer; returns the pin levels after the update
  function automatic pin_result_t sequencer_tick(input logic start, input logic mode,
                                                 input logic [7:0] addr,
                                                 input logic [6:0] wval, input logic line);
    logic [7:0]  span;
    int          dec;
    int          tens_digit;
    int          ones_digit;
    logic        done;
    pin_result_t r;
    span = (seq_half_period == 8'd0) ? 8'd1 : seq_half_period;
    done = 1'b0;
    if (seq_phase == SEQ_IDLE) begin
      if (start) begin
        seq_read = (mode == MODE_READ);
        seq_shift = seq_read ? addr + 8'd1 : addr;
        dec = (wval > 7'd99) ? 99 : int'(wval);
        tens_digit = dec / 10;
        ones_digit = dec % 10;
        seq_data_bcd = {tens_digit[3:0], ones_digit[3:0]};
        seq_bit = '0;
        seq_second_byte = 1'b0;
        seq_phase = SEQ_TX_LOW;
        seq_ticks = 8'd1;
      end
    end else if (seq_ticks < span) begin
      seq_ticks = seq_ticks + 8'd1;
    end else begin
      seq_ticks = 8'd1;
      case (seq_phase)
        SEQ_TX_LOW: begin
          seq_phase = SEQ_TX_HIGH;
        end
        SEQ_TX_HIGH: begin
          if (seq_bit != 3'd7) begin
            seq_bit = seq_bit + 3'd1;
            seq_phase = SEQ_TX_LOW;
          end else if (!seq_second_byte) begin
            seq_bit = '0;
            if (seq_read) begin
              seq_shift = '0;
              seq_phase = SEQ_RX_LOW;
            end else begin
              seq_second_byte = 1'b1;
              seq_shift = seq_data_bcd;
              seq_phase = SEQ_TX_LOW;
            end
          end else begin
            seq_phase = SEQ_IDLE;
            seq_ticks = '0;
            done = 1'b1;
          end
        end
        SEQ_RX_LOW: begin
          // sample on the last tick of the low phase
          if (line) seq_shift[seq_bit] = 1'b1;
          if (seq_bit == 3'd7) begin
            seq_read_value = seq_shift[7:4] * 8'd10 + seq_shift[3:0];
            seq_phase = SEQ_IDLE;
            seq_ticks = '0;
            done = 1'b1;
          end else begin
            seq_phase = SEQ_RX_HIGH;
          end
        end
        default: begin
          seq_bit = seq_bit + 3'd1;
          seq_phase = SEQ_RX_LOW;
        end
      endcase
    end
    r = '0;
    r.chip_enable  = (seq_phase != SEQ_IDLE);
    r.busy         = (seq_phase != SEQ_IDLE);
    r.serial_clock = (seq_phase == SEQ_TX_HIGH) || (seq_phase == SEQ_RX_HIGH);
    r.line_drive   = (seq_phase == SEQ_TX_LOW) || (seq_phase == SEQ_TX_HIGH);
    r.line_out     = r.line_drive ? seq_shift[seq_bit] : 1'b0;
    r.done         = done;
    r.read_value   = seq_read_value;
    return r;
  endfunction

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one tick transfer; the expectation is queued when it is accepted
  task automatic send_tick(input logic start, input logic mode, input logic [7:0] addr,
                           input logic [6:0] wval, input logic line);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {7'd0, line, wval, addr, start};
    in_tuser  <= mode;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pin_levels_due.push_back(sequencer_tick(start, mode, addr, wval, line));
    ticks_sent++;
    @(negedge clk);
  endtask

  // swap the newest expectation for a typed one
  task automatic pin_expected(input int word);
    if (word >= 0) pin_levels_due[pin_levels_due.size() - 1] = pin_result_t'(word[15:0]);
  endtask

  // start tick, then noise on the request fields until the access closes
  task automatic run_access(input logic mode, input logic [7:0] addr, input logic [6:0] wval,
                            input logic [7:0] rx_byte, input int first_word,
                            input int done_word);
    send_tick(1'b1, mode, addr, wval, 1'($urandom));
    pin_expected(first_word);
    while (seq_phase != SEQ_IDLE)
      send_tick(1'($urandom), 1'($urandom), 8'($urandom), 7'($urandom),
                (seq_phase == SEQ_RX_LOW) ? rx_byte[seq_bit] : 1'($urandom));
    pin_expected(done_word);
  endtask

  task automatic expect_half_period(input logic [7:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_paddr   <= HALF_PERIOD_ADDR;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {{(twrtc_pkg::CFG_DATA_W - 8){1'b0}}, value}) begin
      $display("%0t ns: half_period_ticks readback expected %0d, got %0d",
               $time, value, cfg_prdata);
      failures++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // register write once the block has gone quiet, then read it back
  task automatic set_half_period(input logic [7:0] value);
    in_tvalid <= 1'b0;
    while (pin_levels_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= HALF_PERIOD_ADDR;
    cfg_pwdata  <= {{(twrtc_pkg::CFG_DATA_W - 8){1'b0}}, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    seq_half_period = value;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    expect_half_period(value);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      failures++;
    end
  endtask

  // result side backpressure
  always @(negedge clk) begin
    if (stall_left == 0) stall_left = steady ? 0 : pick_gap();
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker: each transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_levels = pin_result_t'(out_tdata);
      if (pin_levels_due.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got %h", $time, out_tdata);
        failures++;
      end else begin
        want_levels = pin_levels_due.pop_front();
        check_field("chip_enable", 8'(want_levels.chip_enable),
                    8'(seen_levels.chip_enable));
        check_field("serial_clock", 8'(want_levels.serial_clock),
                    8'(seen_levels.serial_clock));
        check_field("line_out", 8'(want_levels.line_out), 8'(seen_levels.line_out));
        check_field("line_drive", 8'(want_levels.line_drive), 8'(seen_levels.line_drive));
        check_field("busy_res", 8'(want_levels.busy), 8'(seen_levels.busy));
        check_field("done_res", 8'(want_levels.done), 8'(seen_levels.done));
        check_field("read_value", want_levels.read_value, seen_levels.read_value);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    expect_half_period(twrtc_pkg::HALF_PERIOD_RESET);

    // directed accesses
    foreach (directed_rows[i]) begin
      if (directed_rows[i].half_period >= 0)
        set_half_period(directed_rows[i].half_period[7:0]);
      steady = (seq_half_period > 8'd16);
      if (directed_rows[i].start) begin
        run_access(directed_rows[i].mode, directed_rows[i].address,
                   directed_rows[i].write_value, directed_rows[i].rx_byte,
                   directed_rows[i].first_word, directed_rows[i].done_word);
      end else begin
        send_tick(1'b0, 1'($urandom), 8'($urandom), 7'($urandom), 1'($urandom));
        pin_expected(directed_rows[i].first_word);
      end
    end

    // random phases: new half period, a few accesses with idle ticks between
    random_start = ticks_sent;
    while (ticks_sent < random_start + RANDOM_TICKS) begin
      set_half_period(8'((($urandom_range(0, 9) < 7) ? $urandom_range(0, 3)
                                                     : $urandom_range(4, 12))));
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 6)) begin
        repeat ($urandom_range(0, 3))
          send_tick(1'b0, 1'($urandom), 8'($urandom), 7'($urandom), 1'($urandom));
        run_access(1'($urandom), 8'($urandom), 7'($urandom_range(0, 127)), 8'($urandom),
                   PREDICTED, PREDICTED);
      end
    end

    in_tvalid <= 1'b0;
    while (pin_levels_due.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (failures == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
